FILE: sv/edfs_pkg.sv
// Shared types, constants and opcodes of the EDF task scheduler.
package edfs_pkg;

    localparam int ID_BITS       = 8;
    localparam int TIME_BITS     = 32;
    localparam int OP_BITS       = 2;
    localparam int MAX_TASKS_DEF = 16;

    localparam logic [OP_BITS-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_COMPLETE = 2'd2;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] deadline;
        logic [TIME_BITS-1:0] now;
    } t_in_req;

    typedef struct packed {
        logic                 done_valid;
        logic [ID_BITS-1:0]   done_id;
        logic [TIME_BITS-1:0] done_time;
        logic                 mismatch_error;
        logic                 store_full;
        logic                 overdue_valid;
        logic [ID_BITS-1:0]   overdue_id;
        logic                 preempt_valid;
        logic [ID_BITS-1:0]   preempted_id;
        logic                 running_valid;
        logic [ID_BITS-1:0]   running_id;
    } t_out_res;

    // Classified request handed from the front queue to the core.
    typedef struct packed {
        logic                 is_release;
        logic                 is_complete;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] deadline;
        logic [TIME_BITS-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] dl;
    } t_entry;

endpackage

FILE: sv/edfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module edfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/edfs_front.sv
// Request intake: classify opcodes and hold them in a two-entry queue.
module edfs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  edfs_pkg::t_in_req i_in_req,
    output logic             o_q_valid,
    input  logic             i_q_pop,
    output edfs_pkg::t_cmd   o_q_cmd
);
    import edfs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       cmd;

    // Unused opcode behaves as a plain tick.
    always_comb begin
        cmd.is_release  = (i_in_req.opcode == OP_RELEASE);
        cmd.is_complete = (i_in_req.opcode == OP_COMPLETE);
        cmd.task_id     = i_in_req.task_id;
        cmd.deadline    = i_in_req.deadline;
        cmd.now         = i_in_req.now;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_cmd    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: sv/edfs_core.sv
// Scheduler core: sorted store walk, overdue/preempt/dispatch checks, result register.
module edfs_core #(
    parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  edfs_pkg::t_cmd      i_q_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output edfs_pkg::t_out_res  o_out_res
);
    import edfs_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_REM_RD  = 4'd3;
    localparam logic [3:0] S_REM_CMP = 4'd4;
    localparam logic [3:0] S_SHF_RD  = 4'd5;
    localparam logic [3:0] S_SHF_WR  = 4'd6;
    localparam logic [3:0] S_CHECK   = 4'd7;
    localparam logic [3:0] S_HEAD    = 4'd8;
    localparam logic [3:0] S_HEAD_CMP= 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_k, n_k;
    logic                 r_run, n_run;
    logic [ID_BITS-1:0]   r_run_id, n_run_id;
    logic [TIME_BITS-1:0] r_run_dl, n_run_dl;
    t_cmd                 r_cmd, n_cmd;
    t_out_res             r_res, n_res;
    logic [ID_BITS-1:0]   r_rm_id, n_rm_id;
    logic                 r_rm_ovd, n_rm_ovd;
    logic                 r_out_valid, n_out_valid;
    t_out_res             r_out_res, n_out_res;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [CW-1:0] k_inc;

    edfs_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_TASKS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign k_inc = r_k + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_run       = r_run;
        n_run_id    = r_run_id;
        n_run_dl    = r_run_dl;
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_rm_id     = r_rm_id;
        n_rm_ovd    = r_rm_ovd;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        waddr       = r_k[AW-1:0];
        wdata       = rdata;
        raddr       = r_k[AW-1:0];

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_res    = '0;
                    n_rm_ovd = 1'b0;
                    n_state  = S_CHECK;
                    if (i_q_cmd.is_complete && r_run) begin
                        if (i_q_cmd.task_id == r_run_id) begin
                            n_res.done_valid = 1'b1;
                            n_res.done_id    = r_run_id;
                            n_res.done_time  = i_q_cmd.now;
                            n_rm_id          = r_run_id;
                            n_run            = 1'b0;
                            n_run_id         = '0;
                            n_run_dl         = '0;
                            n_k              = '0;
                            n_state          = S_REM_RD;
                        end else begin
                            n_res.mismatch_error = 1'b1;
                        end
                    end else if (i_q_cmd.is_release) begin
                        if (r_count >= FULL) begin
                            n_res.store_full = 1'b1;
                        end else begin
                            n_k     = r_count;
                            n_state = S_INS_RD;
                        end
                    end
                end
            end
            // Walk down from the top, shifting later deadlines up one slot.
            S_INS_RD: begin
                if (r_k == '0) begin
                    we      = 1'b1;
                    waddr   = '0;
                    wdata   = '{id: r_cmd.task_id, dl: r_cmd.deadline};
                    n_count = r_count + 1'b1;
                    n_state = S_CHECK;
                end else begin
                    raddr   = AW'(r_k - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                we = 1'b1;
                if (rdata.dl > r_cmd.deadline) begin
                    wdata   = rdata;
                    n_k     = r_k - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    wdata   = '{id: r_cmd.task_id, dl: r_cmd.deadline};
                    n_count = r_count + 1'b1;
                    n_state = S_CHECK;
                end
            end
            // Find the first entry with the running id.
            S_REM_RD: begin
                if (r_k >= r_count) begin
                    n_state = r_rm_ovd ? S_HEAD : S_CHECK;
                end else begin
                    n_state = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                if (rdata.id == r_rm_id) begin
                    n_state = S_SHF_RD;
                end else begin
                    n_k     = k_inc;
                    n_state = S_REM_RD;
                end
            end
            // Close the gap by moving later entries down one slot.
            S_SHF_RD: begin
                if (k_inc >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = r_rm_ovd ? S_HEAD : S_CHECK;
                end else begin
                    raddr   = k_inc[AW-1:0];
                    n_state = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                we      = 1'b1;
                wdata   = rdata;
                n_k     = k_inc;
                n_state = S_SHF_RD;
            end
            S_CHECK: begin
                if (r_run && (r_cmd.now > r_run_dl)) begin
                    n_res.overdue_valid = 1'b1;
                    n_res.overdue_id    = r_run_id;
                    n_rm_id             = r_run_id;
                    n_rm_ovd            = 1'b1;
                    n_run               = 1'b0;
                    n_run_id            = '0;
                    n_run_dl            = '0;
                    n_k                 = '0;
                    n_state             = S_REM_RD;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                raddr   = '0;
                n_state = (r_count == '0) ? S_FIN : S_HEAD_CMP;
            end
            S_HEAD_CMP: begin
                if (!r_run || (rdata.dl < r_run_dl)) begin
                    if (r_run) begin
                        n_res.preempt_valid = 1'b1;
                        n_res.preempted_id  = r_run_id;
                    end
                    n_run    = 1'b1;
                    n_run_id = rdata.id;
                    n_run_dl = rdata.dl;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid               = 1'b1;
                    n_out_res                 = r_res;
                    n_out_res.running_valid   = r_run;
                    n_out_res.running_id      = r_run ? r_run_id : '0;
                    n_state                   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_cmd     <= n_cmd;
        r_res     <= n_res;
        r_rm_id   <= n_rm_id;
        r_out_res <= n_out_res;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_run       <= 1'b0;
            r_run_id    <= '0;
            r_run_dl    <= '0;
            r_rm_ovd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_run       <= n_run;
            r_run_id    <= n_run_id;
            r_run_dl    <= n_run_dl;
            r_rm_ovd    <= n_rm_ovd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
endmodule

FILE: sv/edf_task_scheduler.sv
// Top level of the earliest-deadline-first task scheduler.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready   i_in_req   (edfs_pkg::t_in_req)
//  result    out        o_out_valid / i_out_ready o_out_res  (edfs_pkg::t_out_res)
//
// Work: a tick request passes the check, head and finish states of the core,
//   skipping the head compare when the store is empty; a release first walks down
//   past every stored entry with a later deadline, then places the new entry;
//   a completion or an overdue drop first scans for the entry and shifts later
//   entries down. The single read port of the task store makes each walk serial.
// Reset: synchronous, active low; clears the queue, task count and running task.
//   The store itself is not cleared; only entries below the count are ever used.
// Stalls: a two-entry request queue keeps taking requests while the core walks
//   the store, and the result register holds a finished result while the next
//   request is already in work.
module edf_task_scheduler #(
    parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  edfs_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output edfs_pkg::t_out_res o_out_res
);
    import edfs_pkg::*;

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // Front: decode opcodes and queue requests.
    edfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_cmd    (q_cmd)
    );

    // Back: advance the scheduler one pass per queued request.
    edfs_core #(.MAX_TASKS(MAX_TASKS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_cmd     (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );
endmodule

FILE: sv/edfs_checker.sv
// Port-level checks of the EDF scheduler and their bind to the top level.
module edfs_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  edfs_pkg::t_out_res o_out_res
);
    import edfs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_res))
        else $error("result dropped or changed while stalled");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.done_valid |->
            !o_out_res.mismatch_error && !o_out_res.store_full &&
            !o_out_res.overdue_valid)
        else $error("completion reported together with another event");

    a_preempt_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.preempt_valid |->
            o_out_res.running_valid && !o_out_res.overdue_valid)
        else $error("preemption without a running task");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.running_valid |-> o_out_res.running_id == '0)
        else $error("running id set while nothing runs");
endmodule

bind edf_task_scheduler edfs_checker u_edfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_res   (o_out_res)
);
